/* hdl/slpe_pkg.sv */
// ----------------------------------------------------------------------------
// slpe_pkg
// Shared codes and types for the straight-line program evaluator.
// ----------------------------------------------------------------------------
package slpe_pkg;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_OP   = 1'b1;

   localparam logic [1:0] FUNC_ADD  = 2'd0;
   localparam logic [1:0] FUNC_SUB  = 2'd1;
   localparam logic [1:0] FUNC_MUL  = 2'd2;
   // spare code, decodes as multiply
   localparam logic [1:0] FUNC_RSVD = 2'd3;

   // where an operand comes from once decoded
   typedef enum logic [1:0] {
      SRC_ZERO    = 2'd0,
      SRC_INPUT   = 2'd1,
      SRC_RESULT  = 2'd2,
      SRC_LITERAL = 2'd3
   } src_type;

   typedef struct packed {
      logic       bad;
      logic       last;
      logic [1:0] func;
      src_type    a_src;
      src_type    b_src;
   } op_ctrl_type;

endpackage

/* hdl/straight_line_program_evaluator_core.sv */
// ----------------------------------------------------------------------------
// straight_line_program_evaluator_core
// Straight-line program evaluator: loads inputs, runs add/sub/mul ops.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer. A load writes req_load_value
//   into input slot req_load_slot and gives no result. An op reads its
//   operands from the input store, the result store or a literal, computes
//   add, subtract or multiply with wrap, stores the result at the running
//   op position and returns one rsp_* transfer.
//   csr_write_enable/csr_write_data set the input count; write it only
//   while no op is in flight.
//   Path: an op's result passes the stage 1 registers, the stage 2
//   registers and the output register before it is presented on rsp_*.
//   Throughput: one item per cycle while req_stall is low. An op that reads
//   the result of the op directly before it waits under req_stall, as that
//   result is still in stage 1; older results come from the result RAM or
//   from the output register by forwarding.
//   Reset clears the op position and sets the input count to 64. Both
//   stores hold nothing defined until written; no clearing pass is run.
//   While a result waits under rsp_stall the pipeline holds and req_stall
//   is raised.
// ----------------------------------------------------------------------------
module straight_line_program_evaluator_core
   import slpe_pkg::*;
#(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_OPS     = 1024,
   parameter int VALUE_WIDTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [6:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [5:0]         req_load_slot,
   input  logic signed [63:0] req_load_value,
   input  logic [1:0]         req_op_function,
   input  logic signed [10:0] req_src1_index,
   input  logic               req_src2_is_literal,
   input  logic signed [63:0] req_src2_operand,
   input  logic               req_last_op,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_result_value,
   output logic [9:0]         rsp_result_position,
   output logic               rsp_bad_reference,
   output logic               rsp_program_done
);

   localparam int IW = MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1;
   localparam int PW = $clog2(MAX_OPS);
   localparam logic [PW:0]  MaxOps    = (PW + 1)'(MAX_OPS);
   localparam logic [63:0]  MaxInputs = 64'(MAX_INPUTS);

   logic [PW-1:0]  op_position_ff, op_position_in;
   logic [6:0]     input_count_ff, input_count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           fwd_valid_ff, fwd_valid_in;
   logic [63:0]    out_value_ff;
   logic [PW-1:0]  out_pos_ff;
   logic           out_bad_ff;
   logic           out_last_ff;

   logic           accept, issue, load_we, advance, hazard;
   logic [PW:0]    pos_next;
   logic [63:0]    out_pos_wide;

   op_ctrl_type    dec_ctrl;
   logic [IW-1:0]  a_in_addr, b_in_addr;
   logic [PW-1:0]  a_res_addr, b_res_addr;
   logic [63:0]    dec_literal;

   logic [VALUE_WIDTH-1:0] in_rd_a, in_rd_b, res_rd_a, res_rd_b;

   logic           s1_valid;
   logic [PW-1:0]  s1_pos;
   logic           done_valid, done_bad, done_last;
   logic [PW-1:0]  done_pos;
   logic [63:0]    done_value;

   slpe_decode #(
      .MAX_INPUTS (MAX_INPUTS),
      .MAX_OPS    (MAX_OPS),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_decode (
      .op_function    (req_op_function),
      .src1_index     (req_src1_index),
      .src2_is_literal(req_src2_is_literal),
      .src2_operand   (req_src2_operand),
      .last_op        (req_last_op),
      .op_position    (op_position_ff),
      .input_count    (input_count_ff),
      .ctrl           (dec_ctrl),
      .a_in_addr      (a_in_addr),
      .b_in_addr      (b_in_addr),
      .a_res_addr     (a_res_addr),
      .b_res_addr     (b_res_addr),
      .literal        (dec_literal)
   );

   // the op in stage 1 has no result anywhere yet
   assign hazard = (req_command == CMD_OP) && s1_valid &&
                   (((dec_ctrl.a_src == SRC_RESULT) && (a_res_addr == s1_pos)) ||
                    ((dec_ctrl.b_src == SRC_RESULT) && (b_res_addr == s1_pos)));

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance || hazard;
   assign accept    = req_valid && !req_stall;
   assign issue     = accept && (req_command == CMD_OP);
   assign load_we   = accept && (req_command == CMD_LOAD) &&
                      (64'(req_load_slot) < MaxInputs);

   slpe_ram #(
      .WIDTH(VALUE_WIDTH),
      .DEPTH(MAX_INPUTS)
   ) u_input_ram (
      .clock    (clock),
      .wr_en    (load_we),
      .wr_addr  (IW'(req_load_slot)),
      .wr_data  (req_load_value[VALUE_WIDTH-1:0]),
      .rd_en    (issue),
      .rd_addr_a(a_in_addr),
      .rd_addr_b(b_in_addr),
      .rd_data_a(in_rd_a),
      .rd_data_b(in_rd_b)
   );

   slpe_ram #(
      .WIDTH(VALUE_WIDTH),
      .DEPTH(MAX_OPS)
   ) u_result_ram (
      .clock    (clock),
      .wr_en    (advance && done_valid),
      .wr_addr  (done_pos),
      .wr_data  (done_value[VALUE_WIDTH-1:0]),
      .rd_en    (issue),
      .rd_addr_a(a_res_addr),
      .rd_addr_b(b_res_addr),
      .rd_data_a(res_rd_a),
      .rd_data_b(res_rd_b)
   );

   slpe_alu #(
      .POS_WIDTH  (PW),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_alu (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .issue     (issue),
      .ctrl_in   (dec_ctrl),
      .pos_in    (op_position_ff),
      .a_addr_in (a_res_addr),
      .b_addr_in (b_res_addr),
      .literal_in(dec_literal),
      .in_rd_a   (in_rd_a),
      .in_rd_b   (in_rd_b),
      .res_rd_a  (res_rd_a),
      .res_rd_b  (res_rd_b),
      .fwd_valid (fwd_valid_ff),
      .fwd_pos   (out_pos_ff),
      .fwd_value (out_value_ff),
      .s1_valid  (s1_valid),
      .s1_pos    (s1_pos),
      .done_valid(done_valid),
      .done_pos  (done_pos),
      .done_bad  (done_bad),
      .done_last (done_last),
      .done_value(done_value)
   );

   assign pos_next = {1'b0, op_position_ff} + (PW + 1)'(1);

   always_comb begin
      op_position_in = op_position_ff;
      if (issue) begin
         if (req_last_op || (pos_next >= MaxOps)) begin
            op_position_in = '0;
         end else begin
            op_position_in = pos_next[PW-1:0];
         end
      end
   end

   assign input_count_in = csr_write_enable ? csr_write_data : input_count_ff;
   assign rsp_valid_in   = advance ? done_valid : rsp_valid_ff;
   // marks that the output register took its result at the last transfer edge
   assign fwd_valid_in   = advance ? done_valid : fwd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_position_ff <= '0;
         input_count_ff <= 7'd64;
         rsp_valid_ff   <= 1'b0;
         fwd_valid_ff   <= 1'b0;
      end else begin
         op_position_ff <= op_position_in;
         input_count_ff <= input_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         fwd_valid_ff   <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && done_valid) begin
         out_value_ff <= done_value;
         out_pos_ff   <= done_pos;
         out_bad_ff   <= done_bad;
         out_last_ff  <= done_last;
      end
   end

   assign out_pos_wide        = 64'(out_pos_ff);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_value    = out_value_ff;
   assign rsp_result_position = out_pos_wide[9:0];
   assign rsp_bad_reference   = out_bad_ff;
   assign rsp_program_done    = out_last_ff;

   // last op restarts the program
   assert property (@(posedge clock) disable iff (reset)
      (issue && req_last_op) |=> (op_position_ff == '0))
      else $error("op position not cleared after last op");

   // an issued op sits in stage 1 next cycle at the position it was given
   assert property (@(posedge clock) disable iff (reset)
      issue |=> (s1_valid && (s1_pos == $past(op_position_ff))))
      else $error("issued op missing from stage 1");

   // a taken result with nothing behind it leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !done_valid) |=> !rsp_valid_ff)
      else $error("result repeated on output");

endmodule

/* hdl/slpe_ram.sv */
// ----------------------------------------------------------------------------
// slpe_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module slpe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                        rd_data_a,
   output logic [WIDTH-1:0]                        rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hdl/slpe_decode.sv */
// ----------------------------------------------------------------------------
// slpe_decode
// Operand decode: classifies each index, checks range and forms addresses.
// ----------------------------------------------------------------------------
module slpe_decode
   import slpe_pkg::*;
#(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_OPS     = 1024,
   parameter int VALUE_WIDTH = 64
) (
   input  logic [1:0]                  op_function,
   input  logic signed [10:0]          src1_index,
   input  logic                        src2_is_literal,
   input  logic signed [63:0]          src2_operand,
   input  logic                        last_op,
   input  logic [$clog2(MAX_OPS)-1:0]  op_position,
   input  logic [6:0]                  input_count,
   output op_ctrl_type                 ctrl,
   output logic [(MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1)-1:0] a_in_addr,
   output logic [(MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1)-1:0] b_in_addr,
   output logic [$clog2(MAX_OPS)-1:0]  a_res_addr,
   output logic [$clog2(MAX_OPS)-1:0]  b_res_addr,
   output logic [63:0]                 literal
);

   localparam int IW = MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1;
   localparam int PW = $clog2(MAX_OPS);
   localparam int SH = 64 - VALUE_WIDTH;
   localparam logic [63:0] MaxInputs = 64'(MAX_INPUTS);

   logic [63:0]        idx1;
   logic [63:0]        inv1;
   logic [63:0]        inv2;
   logic [63:0]        cnt;
   logic [63:0]        pos_wide;
   logic signed [63:0] lit_shl;
   src_type            a_kind;
   src_type            b_kind;

   function automatic src_type ref_kind(logic [63:0] idx, logic [63:0] count,
                                        logic [63:0] pos);
      src_type k;
      k = SRC_ZERO;
      if (idx[63]) begin
         if (~idx < count) begin
            k = SRC_INPUT;
         end
      end else if (idx < pos) begin
         k = SRC_RESULT;
      end
      return k;
   endfunction

   assign idx1     = 64'(src1_index);
   assign inv1     = ~idx1;
   assign inv2     = ~src2_operand;
   assign pos_wide = 64'(op_position);
   assign cnt      = (64'(input_count) < MaxInputs) ? 64'(input_count) : MaxInputs;

   assign a_kind = ref_kind(idx1, cnt, pos_wide);
   assign b_kind = src2_is_literal ? SRC_LITERAL : ref_kind(src2_operand, cnt, pos_wide);

   assign a_in_addr  = inv1[IW-1:0];
   assign b_in_addr  = inv2[IW-1:0];
   assign a_res_addr = idx1[PW-1:0];
   assign b_res_addr = src2_operand[PW-1:0];

   // literal kept at value width, sign extended
   assign lit_shl = src2_operand <<< SH;
   assign literal = lit_shl >>> SH;

   always_comb begin
      ctrl       = '0;
      ctrl.bad   = (a_kind == SRC_ZERO) || (b_kind == SRC_ZERO);
      ctrl.last  = last_op;
      ctrl.func  = op_function;
      ctrl.a_src = a_kind;
      ctrl.b_src = b_kind;
   end

endmodule

/* hdl/slpe_alu.sv */
// ----------------------------------------------------------------------------
// slpe_alu
// Two-stage datapath: operand select with forwarding, add/sub and partial
// products, then product sum and result wrap.
// ----------------------------------------------------------------------------
module slpe_alu
   import slpe_pkg::*;
#(
   parameter int POS_WIDTH   = 10,
   parameter int VALUE_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   issue,
   input  op_ctrl_type            ctrl_in,
   input  logic [POS_WIDTH-1:0]   pos_in,
   input  logic [POS_WIDTH-1:0]   a_addr_in,
   input  logic [POS_WIDTH-1:0]   b_addr_in,
   input  logic [63:0]            literal_in,
   input  logic [VALUE_WIDTH-1:0] in_rd_a,
   input  logic [VALUE_WIDTH-1:0] in_rd_b,
   input  logic [VALUE_WIDTH-1:0] res_rd_a,
   input  logic [VALUE_WIDTH-1:0] res_rd_b,
   input  logic                   fwd_valid,
   input  logic [POS_WIDTH-1:0]   fwd_pos,
   input  logic [63:0]            fwd_value,
   output logic                   s1_valid,
   output logic [POS_WIDTH-1:0]   s1_pos,
   output logic                   done_valid,
   output logic [POS_WIDTH-1:0]   done_pos,
   output logic                   done_bad,
   output logic                   done_last,
   output logic [63:0]            done_value
);

   localparam int SH = 64 - VALUE_WIDTH;

   logic                 s1_valid_ff, s1_valid_in;
   op_ctrl_type          s1_ctrl_ff;
   logic [POS_WIDTH-1:0] s1_pos_ff;
   logic [POS_WIDTH-1:0] s1_a_addr_ff;
   logic [POS_WIDTH-1:0] s1_b_addr_ff;
   logic [63:0]          s1_lit_ff;

   logic                 s2_valid_ff, s2_valid_in;
   op_ctrl_type          s2_ctrl_ff;
   logic [POS_WIDTH-1:0] s2_pos_ff;
   logic [63:0]          s2_sum_ff, s2_sum_in;
   logic [63:0]          s2_ll_ff, s2_ll_in;
   logic [31:0]          s2_cross_ff, s2_cross_in;

   logic [63:0]          op_a, op_b;
   logic [31:0]          lh, hl;
   logic [63:0]          product;
   logic signed [63:0]   raw;
   logic signed [63:0]   raw_shl;

   function automatic logic [63:0] pick(src_type s, logic [VALUE_WIDTH-1:0] inp,
                                        logic [VALUE_WIDTH-1:0] res, logic hit,
                                        logic [63:0] fwd, logic [63:0] lit);
      logic [63:0] v;
      case (s)
         SRC_INPUT:   v = 64'($signed(inp));
         SRC_RESULT:  v = hit ? fwd : 64'($signed(res));
         SRC_LITERAL: v = lit;
         default:     v = '0;
      endcase
      return v;
   endfunction

   // stage 1: the result leaving stage 2 at the read edge is in the output
   // register and not yet visible in the RAM read data
   assign op_a = pick(s1_ctrl_ff.a_src, in_rd_a, res_rd_a,
                      fwd_valid && (fwd_pos == s1_a_addr_ff), fwd_value, s1_lit_ff);
   assign op_b = pick(s1_ctrl_ff.b_src, in_rd_b, res_rd_b,
                      fwd_valid && (fwd_pos == s1_b_addr_ff), fwd_value, s1_lit_ff);

   assign s2_sum_in   = (s1_ctrl_ff.func == FUNC_SUB) ? op_a - op_b : op_a + op_b;
   assign s2_ll_in    = {32'b0, op_a[31:0]} * {32'b0, op_b[31:0]};
   assign lh          = op_a[31:0] * op_b[63:32];
   assign hl          = op_a[63:32] * op_b[31:0];
   assign s2_cross_in = lh + hl;

   assign s1_valid_in = advance ? issue : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && issue) begin
         s1_ctrl_ff   <= ctrl_in;
         s1_pos_ff    <= pos_in;
         s1_a_addr_ff <= a_addr_in;
         s1_b_addr_ff <= b_addr_in;
         s1_lit_ff    <= literal_in;
      end
      if (advance) begin
         s2_ctrl_ff  <= s1_ctrl_ff;
         s2_pos_ff   <= s1_pos_ff;
         s2_sum_ff   <= s2_sum_in;
         s2_ll_ff    <= s2_ll_in;
         s2_cross_ff <= s2_cross_in;
      end
   end

   // stage 2: low 64 bits of the product
   assign product = s2_ll_ff + {s2_cross_ff, 32'b0};

   always_comb begin
      case (s2_ctrl_ff.func)
         FUNC_ADD, FUNC_SUB: raw = s2_sum_ff;
         default:            raw = product;
      endcase
   end

   assign raw_shl    = raw <<< SH;
   assign done_value = raw_shl >>> SH;
   assign done_valid = s2_valid_ff;
   assign done_pos   = s2_pos_ff;
   assign done_bad   = s2_ctrl_ff.bad;
   assign done_last  = s2_ctrl_ff.last;

   assign s1_valid = s1_valid_ff;
   assign s1_pos   = s1_pos_ff;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the straight-line program evaluator core. A scoreboard
// predicts every op result from loads, ops and input count writes, and
// checks each rsp transfer in order. The stimulus covers directed corner
// ops, input count limits, random programs, position wrap and a long
// result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import slpe_pkg::*;

   localparam int CYCLE_LIMIT      = 1000000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 8;
   localparam int RANDOM_ITEMS     = 480;

   typedef struct {
      logic        command;
      logic [5:0]  slot;
      logic [63:0] load_value;
      logic [1:0]  func;
      logic [10:0] src1;
      logic        src2_lit;
      logic [63:0] src2;
      logic        last;
   } eval_cmd_type;

   typedef struct {
      logic [63:0] value;
      logic [9:0]  position;
      logic        bad;
      logic        done;
   } op_result_type;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [6:0]         csr_write_data;
   logic               req_valid;
   logic               req_stall;
   logic               req_command;
   logic [5:0]         req_load_slot;
   logic signed [63:0] req_load_value;
   logic [1:0]         req_op_function;
   logic signed [10:0] req_src1_index;
   logic               req_src2_is_literal;
   logic signed [63:0] req_src2_operand;
   logic               req_last_op;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [63:0] rsp_result_value;
   logic [9:0]         rsp_result_position;
   logic               rsp_bad_reference;
   logic               rsp_program_done;

   // scoreboard state
   logic [63:0]   model_inputs [64];
   bit            input_written [64];
   logic [63:0]   model_results [1024];
   logic [9:0]    model_op_pos;
   logic [6:0]    model_input_count;
   op_result_type op_results_due [$];

   int unsigned mismatch_count;
   int unsigned cycle_count;
   bit          send_idle_on;
   bit          recv_idle_on;
   bit          long_hold_req;

   straight_line_program_evaluator_core uut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_load_slot       (req_load_slot),
      .req_load_value      (req_load_value),
      .req_op_function     (req_op_function),
      .req_src1_index      (req_src1_index),
      .req_src2_is_literal (req_src2_is_literal),
      .req_src2_operand    (req_src2_operand),
      .req_last_op         (req_last_op),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_value    (rsp_result_value),
      .rsp_result_position (rsp_result_position),
      .rsp_bad_reference   (rsp_bad_reference),
      .rsp_program_done    (rsp_program_done)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic int unsigned live_inputs();
      return (model_input_count < 7'd64) ? int'(model_input_count) : 64;
   endfunction

   function automatic logic [63:0] read_operand(input logic [63:0] idx, inout bit bad);
      logic [63:0] k;
      if (idx[63]) begin
         k = ~idx;
         if (k < 64'(live_inputs()))
            return model_inputs[k[5:0]];
         bad = 1'b1;
         return 64'd0;
      end
      if (idx < {54'd0, model_op_pos})
         return model_results[idx[9:0]];
      bad = 1'b1;
      return 64'd0;
   endfunction

   // Applies one accepted command to the model and queues the op result.
   task automatic evaluate_command(input eval_cmd_type c);
      logic [63:0]   a;
      logic [63:0]   b;
      logic [63:0]   r;
      bit            bad;
      op_result_type res;
      bad = 1'b0;
      if (c.command == CMD_LOAD) begin
         model_inputs[c.slot]  = c.load_value;
         input_written[c.slot] = 1'b1;
      end else begin
         a = read_operand({{53{c.src1[10]}}, c.src1}, bad);
         b = c.src2_lit ? c.src2 : read_operand(c.src2, bad);
         case (c.func)
            FUNC_ADD: r = a + b;
            FUNC_SUB: r = a - b;
            default:  r = a * b;  // unused code multiplies too
         endcase
         model_results[model_op_pos] = r;
         res.value    = r;
         res.position = model_op_pos;
         res.bad      = bad;
         res.done     = c.last;
         op_results_due.push_back(res);
         if (c.last || model_op_pos == 10'd1023)
            model_op_pos = 10'd0;
         else
            model_op_pos = model_op_pos + 10'd1;
      end
   endtask

   // ------------------------------------------------------------ generators

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 64'd0;
         1:       return 64'd1;
         2:       return '1;
         3:       return 64'h7fff_ffff_ffff_ffff;
         4:       return 64'h8000_0000_0000_0000;
         5:       return 64'($urandom_range(0, 255));
         6:       return -64'($urandom_range(1, 255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Operand index: mostly valid references, some bad ones. Never names an
   // input slot below the count that has not been loaded.
   function automatic logic [63:0] pick_index(input bit wide);
      int unsigned sel;
      int unsigned eff;
      int unsigned k;
      logic [63:0] kk;
      eff = live_inputs();
      sel = $urandom_range(0, 99);
      if (sel < 40 && model_op_pos > 0) begin
         // lean on the newest results to hit forwarding and the hazard stall
         case ($urandom_range(0, 2))
            0:       k = model_op_pos - 1;
            1:       k = (model_op_pos > 1) ? model_op_pos - 2 : 0;
            default: k = $urandom_range(0, model_op_pos - 1);
         endcase
         kk = 64'(k);
         return kk;
      end else if (sel < 80 && eff > 0) begin
         k  = $urandom_range(0, eff - 1);
         kk = 64'(k);
         if (input_written[k])
            return ~kk;
         kk = 64'(model_op_pos);
         return kk;
      end else if (sel < 88) begin
         k  = $urandom_range(eff, 1023);
         kk = 64'(k);
         return ~kk;
      end else if (sel < 95 || !wide) begin
         k  = $urandom_range(model_op_pos, 1023);
         kk = 64'(k);
         return kk;
      end
      kk     = {$urandom, $urandom};
      kk[62] = ~kk[63];  // keeps it far out of range either way
      return kk;
   endfunction

   function automatic eval_cmd_type make_op(input logic [1:0] func, input logic [10:0] src1,
                                            input logic lit, input logic [63:0] src2,
                                            input logic last);
      eval_cmd_type c;
      c.command    = CMD_OP;
      c.slot       = 6'($urandom);
      c.load_value = {$urandom, $urandom};
      c.func       = func;
      c.src1       = src1;
      c.src2_lit   = lit;
      c.src2       = src2;
      c.last       = last;
      return c;
   endfunction

   function automatic eval_cmd_type make_load(input logic [5:0] slot,
                                              input logic [63:0] value);
      eval_cmd_type c;
      c.command    = CMD_LOAD;
      c.slot       = slot;
      c.load_value = value;
      c.func       = 2'($urandom);
      c.src1       = 11'($urandom);
      c.src2_lit   = 1'($urandom);
      c.src2       = {$urandom, $urandom};
      c.last       = 1'($urandom);
      return c;
   endfunction

   function automatic eval_cmd_type random_op(input logic last);
      logic [10:0] s1;
      logic        lit;
      logic [63:0] s2;
      s1  = 11'(pick_index(1'b0));
      lit = ($urandom_range(0, 9) < 4);
      s2  = lit ? pick_value() : pick_index(1'b1);
      return make_op(2'($urandom_range(0, 3)), s1, lit, s2, last);
   endfunction

   // ------------------------------------------------------------ drivers

   task automatic send_cmd(input eval_cmd_type c);
      int unsigned gap;
      gap = send_idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= c.command;
      req_load_slot       <= c.slot;
      req_load_value      <= c.load_value;
      req_op_function     <= c.func;
      req_src1_index      <= c.src1;
      req_src2_is_literal <= c.src2_lit;
      req_src2_operand    <= c.src2;
      req_last_op         <= c.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      evaluate_command(c);
   endtask

   // Drop valid, let every expected result arrive, then let loads settle.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (op_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_input_count(input logic [6:0] count);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      @(posedge clock);
      csr_write_enable  <= 1'b0;
      model_input_count  = count;
   endtask

   // Result side: random hold-off per transfer, or one long hold on request.
   initial begin : result_sink
      int unsigned hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
         end else begin
            hold = recv_idle_on ? $urandom_range(0, 13) : 0;
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : result_check
      op_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (op_results_due.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual value %h pos %0d",
                     $time, rsp_result_value, rsp_result_position);
            mismatch_count++;
         end else begin
            want = op_results_due.pop_front();
            if (rsp_result_value !== want.value) begin
               $display("%0t: result_value expected %h actual %h",
                        $time, want.value, rsp_result_value);
               mismatch_count++;
            end
            if (rsp_result_position !== want.position) begin
               $display("%0t: result_position expected %0d actual %0d",
                        $time, want.position, rsp_result_position);
               mismatch_count++;
            end
            if (rsp_bad_reference !== want.bad) begin
               $display("%0t: bad_reference expected %b actual %b",
                        $time, want.bad, rsp_bad_reference);
               mismatch_count++;
            end
            if (rsp_program_done !== want.done) begin
               $display("%0t: program_done expected %b actual %b",
                        $time, want.done, rsp_program_done);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------ tests

   // Wrap on add/sub/mul, the unused function code, every operand source,
   // forwarding from the op just before, and each kind of bad reference.
   task automatic test_corner_ops();
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      send_cmd(make_load(6'd0, 64'h7fff_ffff_ffff_ffff));
      send_cmd(make_load(6'd1, 64'h8000_0000_0000_0000));
      send_cmd(make_load(6'd2, '1));
      send_cmd(make_load(6'd3, 64'd1));
      send_cmd(make_load(6'd63, {$urandom, $urandom}));
      send_cmd(make_op(FUNC_ADD, -11'sd1, 1'b0, ~64'd3, 1'b0));
      send_cmd(make_op(FUNC_SUB, -11'sd2, 1'b1, 64'd1, 1'b0));
      send_cmd(make_op(FUNC_MUL, -11'sd1, 1'b0, ~64'd2, 1'b0));
      send_cmd(make_op(FUNC_RSVD, -11'sd3, 1'b1, 64'h8000_0000_0000_0000, 1'b0));
      send_cmd(make_op(FUNC_ADD, 11'sd3, 1'b0, 64'd2, 1'b0));
      send_cmd(make_op(FUNC_SUB, 11'sd4, 1'b0, 64'd4, 1'b0));
      // own position is not written yet
      send_cmd(make_op(FUNC_ADD, 11'sd6, 1'b1, 64'd7, 1'b0));
      send_cmd(make_op(FUNC_ADD, -11'sd64, 1'b1, 64'd0, 1'b0));
      send_cmd(make_op(FUNC_ADD, -11'sd65, 1'b1, 64'd9, 1'b0));
      send_cmd(make_op(FUNC_SUB, 11'sh400, 1'b0, 64'h8000_0000_0000_0000, 1'b0));
      send_cmd(make_op(FUNC_MUL, 11'sd1023, 1'b0, 64'h7fff_ffff_ffff_ffff, 1'b0));
      send_cmd(make_op(FUNC_MUL, 11'sd0, 1'b0, 64'd10, 1'b1));
      // new program: result 0 is stale
      send_cmd(make_op(FUNC_ADD, 11'sd0, 1'b0, ~64'd0, 1'b1));
      wait_quiet();
   endtask

   task automatic test_fill_inputs();
      int i;
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      for (i = 0; i < 64; i++)
         send_cmd(make_load(6'(i), pick_value()));
      wait_quiet();
   endtask

   task automatic test_input_count();
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      write_input_count(7'd0);
      send_cmd(make_op(FUNC_ADD, -11'sd1, 1'b1, 64'd5, 1'b0));
      send_cmd(make_op(FUNC_SUB, 11'sd0, 1'b0, ~64'd2, 1'b1));
      wait_quiet();
      write_input_count(7'd1);
      send_cmd(make_op(FUNC_ADD, -11'sd1, 1'b0, ~64'd1, 1'b0));
      send_cmd(make_op(FUNC_MUL, -11'sd1, 1'b0, ~64'd0, 1'b1));
      wait_quiet();
      // above the store size the count saturates at 64
      write_input_count(7'd127);
      send_cmd(make_op(FUNC_ADD, -11'sd64, 1'b0, ~64'd64, 1'b0));
      send_cmd(make_op(FUNC_SUB, -11'sd64, 1'b0, ~64'd63, 1'b1));
      wait_quiet();
      write_input_count(7'd64);
   endtask

   task automatic test_random_programs();
      int unsigned sent;
      int unsigned next_phase;
      int unsigned len;
      int unsigned i;
      int unsigned mode;
      logic [6:0]  count;
      sent       = 0;
      next_phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= next_phase) begin
            wait_quiet();
            case ($urandom_range(0, 11))
               0:       count = 7'd0;
               1:       count = 7'd1;
               2:       count = 7'd2;
               3:       count = 7'd63;
               4:       count = 7'd65;
               5:       count = 7'd127;
               6:       count = 7'($urandom_range(3, 62));
               default: count = 7'd64;
            endcase
            write_input_count(count);
            mode         = $urandom_range(0, 3);
            send_idle_on = mode[0];
            recv_idle_on = mode[1];
            next_phase   = sent + $urandom_range(100, 200);
         end
         if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
               send_cmd(make_load(6'($urandom), pick_value()));
            sent += len;
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         // now and then the last mark is left off and the program runs on
         for (i = 0; i < len; i++)
            send_cmd(random_op(i == len - 1 && $urandom_range(0, 15) != 0));
         sent += len;
      end
      wait_quiet();
   endtask

   // 1024 ops with no last mark: the position wraps and done stays low.
   task automatic test_position_wrap();
      int i;
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      if (model_op_pos != 10'd0)
         send_cmd(random_op(1'b1));
      for (i = 0; i < 1024; i++)
         send_cmd(random_op(1'b0));
      send_cmd(make_op(FUNC_ADD, 11'sd1, 1'b1, 64'd5, 1'b0));
      for (i = 0; i < 5; i++)
         send_cmd(random_op(1'b0));
      send_cmd(random_op(1'b1));
      wait_quiet();
   endtask

   task automatic test_backpressure();
      int i;
      send_idle_on  = 1'b0;
      recv_idle_on  = 1'b0;
      long_hold_req = 1'b1;
      for (i = 0; i < 40; i++)
         send_cmd(random_op(i == 39));
      wait_quiet();
   endtask

   initial begin
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= 7'd0;
      req_valid           <= 1'b0;
      req_command         <= CMD_LOAD;
      req_load_slot       <= 6'd0;
      req_load_value      <= 64'sd0;
      req_op_function     <= FUNC_ADD;
      req_src1_index      <= 11'sd0;
      req_src2_is_literal <= 1'b0;
      req_src2_operand    <= 64'sd0;
      req_last_op         <= 1'b0;
      mismatch_count    = 0;
      cycle_count       = 0;
      send_idle_on      = 1'b0;
      recv_idle_on      = 1'b0;
      long_hold_req     = 1'b0;
      model_op_pos      = 10'd0;
      model_input_count = 7'd64;
      foreach (input_written[i]) input_written[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_ops();
      test_input_count();
      test_fill_inputs();
      test_random_programs();
      test_position_wrap();
      test_backpressure();
      wait_quiet();

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* filelist.f */
hdl/slpe_pkg.sv
hdl/slpe_ram.sv
hdl/slpe_decode.sv
hdl/slpe_alu.sv
hdl/straight_line_program_evaluator_core.sv
dv/tb_top.sv
